// ===== design/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared constants for the RIFF/WAVE header parser: tags, format codes,
// status codes and the widths of the alignment remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wrp_pkg;

  // Chunk and file tags as they appear in a little-endian 32-bit word.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  localparam logic [15:0] FMT_CODE_PCM   = 16'd1;
  localparam logic [15:0] FMT_CODE_FLOAT = 16'd3;

  // Summary status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF    = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE    = 3'd2;
  localparam logic [2:0] ST_FMT_SHORT   = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
  localparam logic [2:0] ST_MISSING     = 3'd5;
  localparam logic [2:0] ST_MISALIGNED  = 3'd6;
  localparam logic [2:0] ST_TRUNCATED   = 3'd7;

  // Remainder unit widths: data length by block alignment.
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;

endpackage

`default_nettype wire

// ===== design/wrp_remainder.sv =====
// ----------------------------------------------------------------------------
// wrp_remainder
// Restoring remainder unit: one dividend bit per cycle while busy, with the
// remainder valid when done is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module wrp_remainder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [wrp_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [wrp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                                busy,
  output logic                                done,
  output logic [wrp_pkg::DIVISOR_W-1:0]       remainder
);
  import wrp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] num_r;
  logic [DIVISOR_W-1:0]  den_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_nxt;

  // The partial remainder stays below the divisor, so one shifted-in bit
  // needs only one extra bit of headroom.
  always_comb begin
    trial = {rem_r, num_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, den_r};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = diff[DIVISOR_W-1:0];
    end else begin
      rem_nxt = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[DIVIDEND_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== design/wav_riff_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Walks a WAV file byte stream, passes data-chunk bytes on as audio results
// and emits one summary of the format fields, data length and status.
// ----------------------------------------------------------------------------
// A result caused directly by a byte is loaded into the output register in
// the cycle after that byte is accepted.
// One file byte is taken per cycle while no summary is due and the output
// register is free, with the output register parting the two sides.
// A byte that completes both the fmt and data chunks with a nonzero block
// alignment starts the serial remainder unit; its summary is loaded once the
// remainder unit is done and the output register is free.
// A byte with both an audio result and a summary sends the audio result first.
// Reset (rst_n low, synchronous) returns the parser to the start of a file.
`default_nettype none

module wav_riff_header_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tlast,   // stream_end
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] audio_byte, [10:8] status, [26:11] format_tag, [42:27] channels,
  // [74:43] sample_rate, [106:75] byte_rate, [122:107] block_align,
  // [138:123] bits_per_sample, [170:139] data_length, [175:171] zero
  output logic [175:0]      out_tdata,
  output logic              out_tuser,  // kind
  output logic              out_tlast   // run_last
);
  import wrp_pkg::*;

  // Where the parser stands within the file.
  typedef enum logic [2:0] {
    PH_FILEHDR, PH_CHUNKHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD
  } phase_t;

  // Sequencer around the output register and the remainder unit.
  typedef enum logic [1:0] {
    CTL_IDLE, CTL_DIV, CTL_SUM
  } ctl_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] field_count;
    logic [31:0] tag_shift;
    logic [31:0] chunk_length;
    logic [15:0] fmt;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] dlen;
    logic        seen_fmt;
    logic        seen_data;
    logic        finished;
  } parse_t;

  localparam parse_t PARSE_RESET = '{phase: PH_FILEHDR, default: '0};

  function automatic logic [175:0] pack_sum(parse_t s, logic [2:0] st);
    pack_sum = {5'd0, s.dlen, s.bits, s.align, s.brate, s.rate, s.chans, s.fmt,
                st, 8'd0};
  endfunction

  ctl_t          ctl_r;
  parse_t        ps_r;
  parse_t        ps_nxt;
  logic          out_valid_r;
  logic [175:0]  out_data_r;
  logic          out_kind_r;
  logic          out_last_r;
  logic [2:0]    sum_status_r;
  logic          clear_pend_r;

  logic          p_audio;
  logic          p_sum;
  logic          p_mod;
  logic [2:0]    p_status;
  logic [31:0]   tag_in;
  logic [31:0]   len_in;
  logic [31:0]   cnt_inc;
  logic          in_acc;
  logic          out_free;
  logic          out_load;
  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [15:0]   div_rem;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (ctl_r == CTL_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // The output register takes a new result this cycle.
  assign out_load  = (in_acc && (p_audio || (p_sum && !p_mod))) ||
                     (ctl_r == CTL_SUM && out_free);

  // Byte-level parse step: what this byte does to the parser state and which
  // results it causes.
  always_comb begin
    ps_nxt   = ps_r;
    p_audio  = 1'b0;
    p_sum    = 1'b0;
    p_mod    = 1'b0;
    p_status = ST_OK;
    tag_in   = {in_tdata, ps_r.tag_shift[31:8]};
    len_in   = {in_tdata, ps_r.chunk_length[31:8]};
    cnt_inc  = ps_r.field_count + 32'd1;
    if (!ps_r.finished) begin
      unique case (ps_r.phase)
        PH_FILEHDR: begin
          ps_nxt.tag_shift   = tag_in;
          ps_nxt.field_count = cnt_inc;
          if (cnt_inc == 32'd4 && tag_in != TAG_RIFF) begin
            p_sum           = 1'b1;
            p_status        = ST_BAD_RIFF;
            ps_nxt.finished = 1'b1;
          end else if (cnt_inc == 32'd12) begin
            if (tag_in != TAG_WAVE) begin
              p_sum           = 1'b1;
              p_status        = ST_BAD_WAVE;
              ps_nxt.finished = 1'b1;
            end else begin
              ps_nxt.phase       = PH_CHUNKHDR;
              ps_nxt.field_count = '0;
            end
          end
        end
        PH_CHUNKHDR: begin
          if (ps_r.field_count < 32'd4) begin
            ps_nxt.tag_shift = tag_in;
          end else begin
            ps_nxt.chunk_length = len_in;
          end
          ps_nxt.field_count = cnt_inc;
          if (cnt_inc == 32'd8) begin
            ps_nxt.field_count = '0;
            if (ps_r.tag_shift == TAG_FMT) begin
              if (len_in < FMT_MIN_LEN) begin
                p_sum           = 1'b1;
                p_status        = ST_FMT_SHORT;
                ps_nxt.finished = 1'b1;
              end else begin
                ps_nxt.phase = PH_FMT;
              end
            end else if (ps_r.tag_shift == TAG_DATA) begin
              ps_nxt.dlen = len_in;
              if (len_in == '0) begin
                ps_nxt.seen_data = 1'b1;
                ps_nxt.phase     = PH_CHUNKHDR;
              end else begin
                ps_nxt.phase = PH_DATA;
              end
            end else if (len_in == '0) begin
              ps_nxt.phase = PH_CHUNKHDR;
            end else begin
              ps_nxt.phase = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          case (ps_r.field_count[3:0])
            4'd0, 4'd1:   ps_nxt.fmt   = {in_tdata, ps_r.fmt[15:8]};
            4'd2, 4'd3:   ps_nxt.chans = {in_tdata, ps_r.chans[15:8]};
            4'd4, 4'd5, 4'd6, 4'd7:
                          ps_nxt.rate  = {in_tdata, ps_r.rate[31:8]};
            4'd8, 4'd9, 4'd10, 4'd11:
                          ps_nxt.brate = {in_tdata, ps_r.brate[31:8]};
            4'd12, 4'd13: ps_nxt.align = {in_tdata, ps_r.align[15:8]};
            default:      ps_nxt.bits  = {in_tdata, ps_r.bits[15:8]};
          endcase
          ps_nxt.field_count = cnt_inc;
          if (cnt_inc == FMT_MIN_LEN) begin
            if (ps_r.fmt != FMT_CODE_PCM && ps_r.fmt != FMT_CODE_FLOAT) begin
              p_sum           = 1'b1;
              p_status        = ST_UNSUPPORTED;
              ps_nxt.finished = 1'b1;
            end else begin
              ps_nxt.seen_fmt = 1'b1;
              if (ps_r.chunk_length > FMT_MIN_LEN) begin
                // Extra fmt bytes are skipped by the chunk length.
                ps_nxt.phase = PH_SKIP;
              end else begin
                ps_nxt.field_count = '0;
                ps_nxt.phase       = ps_r.chunk_length[0] ? PH_PAD : PH_CHUNKHDR;
              end
            end
          end
        end
        PH_DATA: begin
          p_audio            = 1'b1;
          ps_nxt.field_count = cnt_inc;
          if (cnt_inc == ps_r.chunk_length) begin
            ps_nxt.seen_data   = 1'b1;
            ps_nxt.field_count = '0;
            ps_nxt.phase       = ps_r.chunk_length[0] ? PH_PAD : PH_CHUNKHDR;
          end
        end
        PH_SKIP: begin
          ps_nxt.field_count = cnt_inc;
          if (cnt_inc == ps_r.chunk_length) begin
            ps_nxt.field_count = '0;
            ps_nxt.phase       = ps_r.chunk_length[0] ? PH_PAD : PH_CHUNKHDR;
          end
        end
        default: begin
          ps_nxt.phase       = PH_CHUNKHDR;
          ps_nxt.field_count = '0;
        end
      endcase

      // Both chunks seen: summary; nonzero alignment judged by remainder unit.
      if (!ps_nxt.finished && ps_nxt.seen_fmt && ps_nxt.seen_data) begin
        p_sum           = 1'b1;
        ps_nxt.finished = 1'b1;
        if (ps_nxt.align == '0) begin
          p_status = ST_MISALIGNED;
        end else begin
          p_mod = 1'b1;
        end
      end
      if (!ps_nxt.finished && in_tlast) begin
        p_sum           = 1'b1;
        ps_nxt.finished = 1'b1;
        if (ps_nxt.phase == PH_FILEHDR || ps_nxt.phase == PH_FMT ||
            ps_nxt.phase == PH_DATA) begin
          p_status = ST_TRUNCATED;
        end else begin
          p_status = ST_MISSING;
        end
      end
    end
  end

  assign div_start = in_acc && p_mod;

  wrp_remainder u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (ps_nxt.dlen),
    .divisor   (ps_nxt.align),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Sequencer and output register. A summary that has to wait (behind an
  // audio result or for the remainder) keeps the parser state frozen, and the
  // end-of-stream clear is deferred until that summary is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r        <= CTL_IDLE;
      ps_r         <= PARSE_RESET;
      out_valid_r  <= 1'b0;
      clear_pend_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctl_r)
        CTL_IDLE: begin
          if (in_acc) begin
            if (p_audio) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= 1'b0;
              out_last_r  <= !p_sum;
              out_data_r  <= {168'd0, in_tdata};
            end
            if (p_sum && (p_audio || p_mod)) begin
              ps_r         <= ps_nxt;
              sum_status_r <= p_status;
              clear_pend_r <= in_tlast;
              ctl_r        <= p_mod ? CTL_DIV : CTL_SUM;
            end else begin
              if (p_sum) begin
                out_valid_r <= 1'b1;
                out_kind_r  <= 1'b1;
                out_last_r  <= 1'b1;
                out_data_r  <= pack_sum(ps_nxt, p_status);
              end
              ps_r <= in_tlast ? PARSE_RESET : ps_nxt;
            end
          end
        end
        CTL_DIV: begin
          if (div_done) begin
            sum_status_r <= (div_rem != '0) ? ST_MISALIGNED : ST_OK;
            ctl_r        <= CTL_SUM;
          end
        end
        CTL_SUM: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= 1'b1;
            out_last_r  <= 1'b1;
            out_data_r  <= pack_sum(ps_r, sum_status_r);
            if (clear_pend_r) begin
              ps_r <= PARSE_RESET;
            end
            clear_pend_r <= 1'b0;
            ctl_r        <= CTL_IDLE;
          end
        end
        default: ctl_r <= CTL_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // No new byte is taken while the remainder unit works.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_tready)
    else $error("byte accepted during alignment check");

  // The remainder wait is left only for the summary load.
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == CTL_DIV |=> (ctl_r == CTL_DIV || ctl_r == CTL_SUM))
    else $error("alignment wait left without summary");

  // An ok summary never carries a zero block alignment.
  a_ok_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && out_tdata[10:8] == ST_OK) |-> out_tdata[122:107] != '0)
    else $error("ok status with zero block alignment");

endmodule

`default_nettype wire

// ===== verif/wav_riff_header_parser_test.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser_test
// Self-checking bench for the WAV header parser: drives whole files, broken
// files and noise byte by byte, predicts every audio byte and summary, and
// compares each result with the oldest prediction under random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_riff_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wrp_pkg::*;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    PH_FILEHDR, PH_CHUNKHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD
  } parse_phase_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic         kind;
    logic [175:0] payload;
    logic         last;
  } wav_result_t;

  // One request for the input side.
  typedef struct packed {
    logic [7:0] data;
    logic       stream_end;
  } file_byte_t;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [175:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  wav_riff_header_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #1 clk = ~clk;

  // Predictor state, mirroring the parser's registers.
  parse_phase_t ph;
  logic [31:0] fcount, tag_sr, chunk_len;
  logic [15:0] s_format, s_channels, s_align, s_bits;
  logic [31:0] s_rate, s_byte_rate, s_data_len;
  logic saw_fmt, saw_data, done;

  file_byte_t pending_bytes[$];
  wav_result_t expected_results[$];

  int errors = 0;
  int cycle = 0;
  int n_results = 0;
  int n_summaries = 0;
  int n_accepted = 0;
  logic [7:0] status_mask = '0;

  // Idling controls, in percent, set by the stimulus phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_sender = 1'b0;
  logic long_stall_req = 1'b0;
  int long_stall_left = 0;

  function automatic void clear_parser();
    ph = PH_FILEHDR;
    fcount = '0; tag_sr = '0; chunk_len = '0;
    s_format = '0; s_channels = '0; s_rate = '0; s_byte_rate = '0;
    s_align = '0; s_bits = '0; s_data_len = '0;
    saw_fmt = 1'b0; saw_data = 1'b0; done = 1'b0;
  endfunction

  function automatic wav_result_t make_summary(logic [2:0] st);
    wav_result_t r;
    r.kind = 1'b1;
    r.last = 1'b0;
    r.payload = {5'd0, s_data_len, s_bits, s_align, s_byte_rate, s_rate,
                 s_channels, s_format, st, 8'd0};
    done = 1'b1;
    return r;
  endfunction

  function automatic void close_body();
    fcount = '0;
    ph = chunk_len[0] ? PH_PAD : PH_CHUNKHDR;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Advances the predictor by one accepted byte and queues its results.
  function automatic void parse_byte(logic [7:0] b, logic eos);
    wav_result_t res[$];
    wav_result_t r;
    if (done) begin
      if (eos) clear_parser();
      return;
    end
    case (ph)
      PH_FILEHDR: begin
        tag_sr = {b, tag_sr[31:8]};
        fcount++;
        if (fcount == 4 && tag_sr != TAG_RIFF) begin
          res.push_back(make_summary(ST_BAD_RIFF));
        end else if (fcount == 12) begin
          if (tag_sr != TAG_WAVE) res.push_back(make_summary(ST_BAD_WAVE));
          else begin
            ph = PH_CHUNKHDR;
            fcount = '0;
          end
        end
      end
      PH_CHUNKHDR: begin
        if (fcount < 4) tag_sr = {b, tag_sr[31:8]};
        else chunk_len = {b, chunk_len[31:8]};
        fcount++;
        if (fcount == 8) begin
          fcount = '0;
          if (tag_sr == TAG_FMT) begin
            if (chunk_len < FMT_MIN_LEN) res.push_back(make_summary(ST_FMT_SHORT));
            else ph = PH_FMT;
          end else if (tag_sr == TAG_DATA) begin
            s_data_len = chunk_len;
            if (chunk_len == 0) begin
              saw_data = 1'b1;
              close_body();
            end else ph = PH_DATA;
          end else if (chunk_len == 0) close_body();
          else ph = PH_SKIP;
        end
      end
      PH_FMT: begin
        if (fcount < 2) s_format = {b, s_format[15:8]};
        else if (fcount < 4) s_channels = {b, s_channels[15:8]};
        else if (fcount < 8) s_rate = {b, s_rate[31:8]};
        else if (fcount < 12) s_byte_rate = {b, s_byte_rate[31:8]};
        else if (fcount < 14) s_align = {b, s_align[15:8]};
        else s_bits = {b, s_bits[15:8]};
        fcount++;
        if (fcount == FMT_MIN_LEN) begin
          if (s_format != FMT_CODE_PCM && s_format != FMT_CODE_FLOAT) begin
            res.push_back(make_summary(ST_UNSUPPORTED));
          end else begin
            saw_fmt = 1'b1;
            if (chunk_len > FMT_MIN_LEN) ph = PH_SKIP;
            else close_body();
          end
        end
      end
      PH_DATA: begin
        r = '0;
        r.payload[7:0] = b;
        res.push_back(r);
        fcount++;
        if (fcount == chunk_len) begin
          saw_data = 1'b1;
          close_body();
        end
      end
      PH_SKIP: begin
        fcount++;
        if (fcount == chunk_len) close_body();
      end
      default: begin
        ph = PH_CHUNKHDR;
        fcount = '0;
      end
    endcase
    if (!done && saw_fmt && saw_data) begin
      if (s_align == 0 || (s_data_len % s_align) != 0)
        res.push_back(make_summary(ST_MISALIGNED));
      else
        res.push_back(make_summary(ST_OK));
    end
    if (!done && eos) begin
      if (ph == PH_FILEHDR || ph == PH_FMT || ph == PH_DATA)
        res.push_back(make_summary(ST_TRUNCATED));
      else
        res.push_back(make_summary(ST_MISSING));
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
    if (eos) clear_parser();
  endfunction

  // Stimulus builders: push bytes onto the pending queue.
  task automatic push_byte(logic [7:0] b, logic eos = 1'b0);
    file_byte_t f;
    f.data = b;
    f.stream_end = eos;
    pending_bytes.push_back(f);
  endtask

  task automatic push_word32(logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  task automatic push_word16(logic [15:0] w);
    push_byte(w[7:0]);
    push_byte(w[15:8]);
  endtask

  task automatic push_fmt_chunk(logic [31:0] len, logic [15:0] fmt, logic [15:0] ch,
                                logic [31:0] rate, logic [15:0] align, logic [15:0] bits);
    push_word32(TAG_FMT);
    push_word32(len);
    push_word16(fmt);
    push_word16(ch);
    push_word32(rate);
    push_word32($urandom);
    push_word16(align);
    push_word16(bits);
    for (int i = 16; i < len; i++) push_byte(rand_byte());
    if (len[0]) push_byte(rand_byte());
  endtask

  task automatic push_data_chunk(logic [31:0] len);
    push_word32(TAG_DATA);
    push_word32(len);
    for (int i = 0; i < len; i++) push_byte(rand_byte());
    if (len[0]) push_byte(rand_byte());
  endtask

  task automatic push_other_chunk(logic [31:0] len);
    push_word32($urandom);
    push_word32(len);
    for (int i = 0; i < len; i++) push_byte(rand_byte());
    if (len[0]) push_byte(rand_byte());
  endtask

  // Ends the current file with a stream_end byte of random content.
  task automatic push_end();
    push_byte(rand_byte(), 1'b1);
  endtask

  // A random file: mostly well formed, sometimes damaged or cut short.
  task automatic push_random_file();
    int flavor;
    logic [15:0] align;
    logic [31:0] dlen;
    flavor = $urandom_range(0, 99);
    align = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
    if ($urandom_range(0, 19) == 0) align = 16'hFFFF;
    dlen = $urandom_range(0, 24);
    if (flavor < 4) begin
      // Pure noise, ended.
      repeat ($urandom_range(1, 20)) push_byte(rand_byte());
      push_end();
      return;
    end
    push_word32((flavor < 8) ? $urandom : TAG_RIFF);
    push_word32($urandom);
    push_word32((flavor >= 8 && flavor < 11) ? $urandom : TAG_WAVE);
    if ($urandom_range(0, 3) == 0) push_other_chunk($urandom_range(0, 7));
    if ($urandom_range(0, 1)) begin
      push_fmt_chunk((flavor < 14) ? 32'($urandom_range(0, 15)) : 32'($urandom_range(16, 21)),
                     (flavor < 18) ? 16'($urandom) :
                       (($urandom_range(0, 1)) ? FMT_CODE_PCM : FMT_CODE_FLOAT),
                     16'($urandom), $urandom, align, 16'($urandom));
      if ($urandom_range(0, 4) == 0) push_other_chunk($urandom_range(1, 5));
      push_data_chunk(dlen);
    end else begin
      push_data_chunk(dlen);
      push_fmt_chunk(16 + $urandom_range(0, 3), FMT_CODE_PCM, 16'($urandom), $urandom,
                     align, 16'($urandom));
    end
    // Trailing bytes after the summary, or a truncation when cut short.
    if (flavor >= 90) begin
      repeat ($urandom_range(0, 5)) void'(pending_bytes.pop_back());
    end else begin
      repeat ($urandom_range(0, 3)) push_byte(rand_byte());
    end
    push_end();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offers the head of the pending queue, with random idle gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          file_byte_t f;
          f = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= f.data;
          in_tlast <= f.stream_end;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Every accepted byte steps the predictor.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      parse_byte(in_tdata, in_tlast);
      n_accepted++;
    end
  end

  // Receiver ready, with random stalls and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_stall_req && long_stall_left == 0) begin
      long_stall_left <= 400;
      out_tready <= 1'b0;
    end else if (long_stall_left > 0) begin
      long_stall_left <= long_stall_left - 1;
      out_tready <= (long_stall_left == 1);
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      wav_result_t want;
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind=%b data=%h last=%b",
                 $realtime, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: kind expected %b actual %b", $realtime, want.kind, out_tuser);
          errors++;
        end
        if (out_tdata !== want.payload) begin
          $display("%0t: data expected %h actual %h", $realtime, want.payload, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $realtime, want.last, out_tlast);
          errors++;
        end
        if (want.kind) begin
          n_summaries++;
          status_mask[want.payload[10:8]] = 1'b1;
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files: clean PCM and float, each error status, edge values.
    push_word32(TAG_RIFF); push_word32(32'hFFFF_FFFF); push_word32(TAG_WAVE);
    push_fmt_chunk(16, FMT_CODE_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'd2, 16'hFFFF);
    push_data_chunk(4);
    push_end();
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_other_chunk(3);
    push_fmt_chunk(19, FMT_CODE_FLOAT, 16'd0, 32'd0, 16'd3, 16'd0);
    push_data_chunk(0);
    push_end();
    push_byte(8'hFF); push_byte(8'h00); push_byte(8'hAA); push_byte(8'h55, 1'b1);
    push_word32(TAG_RIFF); push_word32(0); push_word32(32'h0); push_end();
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_word32(TAG_FMT); push_word32(15); push_end();
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_fmt_chunk(16, 16'hFFFE, 16'd1, 32'd1, 16'd1, 16'd8); push_end();
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_fmt_chunk(16, FMT_CODE_PCM, 16'd1, 32'd1, 16'd4, 16'd8);
    push_data_chunk(3); push_end();
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_fmt_chunk(16, FMT_CODE_PCM, 16'd1, 32'd1, 16'd0, 16'd8);
    push_data_chunk(1); push_end();
    push_word32(TAG_RIFF); push_byte(8'h00, 1'b1);
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_data_chunk(2); push_byte(8'h00, 1'b1);
    push_word32(TAG_RIFF); push_word32(0); push_word32(TAG_WAVE);
    push_word32(TAG_DATA); push_word32(6); push_byte(8'h12); push_byte(8'h34, 1'b1);
    wait_drained();

    // The sender pauses until every expected result has come in.
    hold_sender <= 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    hold_sender <= 1'b0;

    // Long receiver hold-off while files keep arriving.
    long_stall_req <= 1'b1;
    @(posedge clk);
    long_stall_req <= 1'b0;
    repeat (4) push_random_file();
    wait_drained();

    // Random files through the four idling phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 29 : 57) : 0;
      recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 29 : 57) : 0;
      while (pending_bytes.size() < 260) push_random_file();
      wait_drained();
      repeat ($urandom_range(0, 40)) @(posedge clk);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d bytes, %0d results, %0d summaries; status codes seen %b.",
             n_accepted, n_results, n_summaries, status_mask);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
